FILE: hw/rtl/ipbd_pkg.sv
// ----------------------------------------------------------------------------
// ipbd_pkg
// Shared constants for the image pyramid box downsampler: default sizes,
// fixed field widths, register map and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipbd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_MAX_LEVELS  = 4;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_DIM_BITS   = 11;
  localparam int CFG_LEVEL_BITS = 3;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  localparam int LEVEL_BITS  = 3;
  localparam int COLUMN_BITS = 9;
  localparam int ROW_BITS    = 9;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVEL_COUNT  = 2'd2;

  localparam logic [CFG_DIM_BITS-1:0]   RESET_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_DIM_BITS-1:0]   RESET_IMAGE_HEIGHT = 11'd480;
  localparam logic [CFG_LEVEL_BITS-1:0] RESET_LEVEL_COUNT  = 3'd3;

endpackage

FILE: hw/rtl/image_pyramid_box_downsampler.sv
// ----------------------------------------------------------------------------
// image_pyramid_box_downsampler
// A beat flows from the job slot via the read-modify-write stage to the output
// register; higher levels follow as cascade jobs. Throughput: one beat per
// cycle unless a cascade job or a stalled output holds the slot; a beat that
// completes blocks at n levels runs min(n + 1, level count) jobs, at most one
// line buffer access each. Reset clears counters, pipeline and registers only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_pyramid_box_downsampler
  import ipbd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   sample,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LEVEL_BITS-1:0]    level,
  output logic [COLUMN_BITS-1:0]   column,
  output logic [ROW_BITS-1:0]      row,
  output logic [SAMPLE_BITS-1:0]   value,
  output logic                     last_of_run,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LCW = $clog2(MAX_LEVELS + 1);
  localparam int AW  = XW;

  logic [CFG_DIM_BITS-1:0]   cfg_width;
  logic [CFG_DIM_BITS-1:0]   cfg_height;
  logic [CFG_LEVEL_BITS-1:0] cfg_levels;

  logic [WW-1:0]  w0;
  logic [HW-1:0]  h0;
  logic [LCW-1:0] lvls;

  logic [XW-1:0] col_cnt [MAX_LEVELS];
  logic [YW-1:0] row_cnt [MAX_LEVELS];

  logic [WW-1:0]         lvl_w   [MAX_LEVELS];
  logic [HW-1:0]         lvl_h   [MAX_LEVELS];
  logic [AW-1:0]         lb_base [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] lvl_in;
  logic [MAX_LEVELS-1:0] lvl_prod;
  logic [MAX_LEVELS-1:0] lvl_prod_up;

  logic                   s0_valid;
  logic [LVW-1:0]         s0_level;
  logic                   s0_cascade;
  logic [SAMPLE_BITS-1:0] s0_sample;
  logic [XW-1:0]          s0_x;
  logic [YW-1:0]          s0_y;
  logic [WW-1:0]          s0_w;
  logic [HW-1:0]          s0_h;
  logic                   s0_in;
  logic                   s0_prod;
  logic                   s0_cont;
  logic                   s0_last;
  logic                   s0_pend_wr;
  logic                   s0_lb_wr;
  logic [AW-1:0]          s0_addr;

  logic                   s1_valid;
  logic [LVW-1:0]         s1_level;
  logic                   s1_cascade;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [COLUMN_BITS-1:0] s1_col;
  logic [ROW_BITS-1:0]    s1_row;
  logic                   s1_prod;
  logic                   s1_last;
  logic                   s1_pend_wr;
  logic                   s1_lb_wr;
  logic [AW-1:0]          s1_addr;
  logic [SAMPLE_BITS-1:0] s1_v;
  logic [SAMPLE_BITS:0]   s1_pair;
  logic [SAMPLE_BITS+1:0] s1_sum;
  logic [SAMPLE_BITS-1:0] s1_mean;

  logic [SAMPLE_BITS-1:0] mean_q;
  logic [SAMPLE_BITS-1:0] pend [MAX_LEVELS];
  logic [SAMPLE_BITS:0]   line_buf [MAX_WIDTH];
  logic [SAMPLE_BITS:0]   lb_rdata;

  logic out_free;
  logic advance;
  logic s0_fire;
  logic s1_fire;
  logic rd_en;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RESET_IMAGE_WIDTH;
      cfg_height <= RESET_IMAGE_HEIGHT;
      cfg_levels <= RESET_LEVEL_COUNT;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_ADDR_BITS-1:2])
        REG_IMAGE_WIDTH:  cfg_width  <= pwdata[CFG_DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= pwdata[CFG_DIM_BITS-1:0];
        REG_LEVEL_COUNT:  cfg_levels <= pwdata[CFG_LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_BITS-1:2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(cfg_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(cfg_height);
      REG_LEVEL_COUNT:  prdata = APB_DATA_BITS'(cfg_levels);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_width < CFG_DIM_BITS'(2)) begin
      w0 = WW'(2);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w0 = WW'(MAX_WIDTH);
    end else begin
      w0 = WW'(cfg_width);
    end
    if (cfg_height < CFG_DIM_BITS'(2)) begin
      h0 = HW'(2);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h0 = HW'(MAX_HEIGHT);
    end else begin
      h0 = HW'(cfg_height);
    end
    if (cfg_levels == '0) begin
      lvls = LCW'(1);
    end else if (32'(cfg_levels) > 32'(MAX_LEVELS)) begin
      lvls = LCW'(MAX_LEVELS);
    end else begin
      lvls = LCW'(cfg_levels);
    end
  end

  // Per-level geometry and block completion, one lane per level.
  always_comb begin
    for (int k = 0; k < MAX_LEVELS; k++) begin
      lvl_w[k]   = w0 >> k;
      lvl_h[k]   = h0 >> k;
      lb_base[k] = AW'(MAX_WIDTH - (MAX_WIDTH >> k));
      lvl_in[k]  = (32'(col_cnt[k]) < 32'(lvl_w[k])) && (32'(row_cnt[k]) < 32'(lvl_h[k]));
      lvl_prod[k] = lvl_in[k] && col_cnt[k][0] && row_cnt[k][0];
    end
    lvl_prod_up = lvl_prod >> 1;
  end

  // Flow control.
  assign out_free = !out_valid || out_ready;
  assign advance  = !(s1_valid && s1_prod && !out_free);
  assign s0_fire  = advance && s0_valid;
  assign s1_fire  = advance && s1_valid;
  assign in_ready = advance && !(s0_valid && s0_cont);
  assign rd_en    = s0_fire && s0_prod;

  // Job slot: one level of one beat, line buffer read issued here.
  assign s0_x       = col_cnt[s0_level];
  assign s0_y       = row_cnt[s0_level];
  assign s0_w       = lvl_w[s0_level];
  assign s0_h       = lvl_h[s0_level];
  assign s0_in      = lvl_in[s0_level];
  assign s0_prod    = lvl_prod[s0_level];
  assign s0_cont    = s0_prod && ((32'(s0_level) + 1) < 32'(lvls));
  assign s0_last    = s0_prod && !(s0_cont && lvl_prod_up[s0_level]);
  assign s0_pend_wr = s0_in && !s0_x[0] && ((32'(s0_x) + 1) < 32'(s0_w));
  assign s0_lb_wr   = s0_in && s0_x[0] && !s0_y[0] && ((32'(s0_y) + 1) < 32'(s0_h));
  assign s0_addr    = lb_base[s0_level] + AW'(s0_x >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '{default: '0};
      row_cnt <= '{default: '0};
    end else if (s0_fire) begin
      if ((32'(s0_x) + 1) >= 32'(s0_w)) begin
        col_cnt[s0_level] <= '0;
        if ((32'(s0_y) + 1) >= 32'(s0_h)) begin
          row_cnt[s0_level] <= '0;
        end else begin
          row_cnt[s0_level] <= s0_y + YW'(1);
        end
      end else begin
        col_cnt[s0_level] <= s0_x + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= (s0_valid && s0_cont) || (in_valid && in_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s0_valid && s0_cont) begin
        s0_level   <= s0_level + LVW'(1);
        s0_cascade <= 1'b1;
      end else begin
        s0_level   <= '0;
        s0_cascade <= 1'b0;
        s0_sample  <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lb_rdata <= line_buf[s0_addr];
    end
  end

  // Read-modify-write stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_level   <= s0_level;
      s1_cascade <= s0_cascade;
      s1_sample  <= s0_sample;
      s1_col     <= COLUMN_BITS'(s0_x >> 1);
      s1_row     <= ROW_BITS'(s0_y >> 1);
      s1_prod    <= s0_prod;
      s1_last    <= s0_last;
      s1_pend_wr <= s0_pend_wr;
      s1_lb_wr   <= s0_lb_wr;
      s1_addr    <= s0_addr;
    end
  end

  assign s1_v    = s1_cascade ? mean_q : s1_sample;
  assign s1_pair = {1'b0, pend[s1_level]} + {1'b0, s1_v};
  assign s1_sum  = {1'b0, lb_rdata} + {1'b0, s1_pair};
  assign s1_mean = s1_sum[SAMPLE_BITS+1:2];

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_pend_wr) begin
        pend[s1_level] <= s1_v;
      end
      mean_q <= s1_mean;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_lb_wr) begin
      line_buf[s1_addr] <= s1_pair;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_prod) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_prod) begin
      level       <= LEVEL_BITS'(32'(s1_level) + 1);
      column      <= s1_col;
      row         <= s1_row;
      value       <= s1_mean;
      last_of_run <= s1_last;
    end
  end

`ifndef ASSERT_OFF
  a_cascade_source: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && s0_cascade) |->
      (s1_valid && s1_prod && (32'(s0_level) == 32'(s1_level) + 1)))
    else $error("cascade job without a producing job one level below");

  a_chain_continues: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_prod && !s1_last) |-> (s0_valid && s0_cascade && s0_prod))
    else $error("result not flagged last but no further result follows");

  a_beat_starts_chain: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (s0_valid && !s0_cascade && (s0_level == '0)))
    else $error("accepted beat did not enter at level zero");
`endif

endmodule

FILE: bench/image_pyramid_box_downsampler_test.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// image_pyramid_box_downsampler_test
// Self-checking bench for the 2x2 box pyramid downsampler. A directed table
// checks register reset values, masking and a few hand-computed blocks. Whole
// frames of random, all-ones, extreme or mixed pixels follow, each under a new
// size and level count. A predictor built into the bench tracks the pyramid
// state and checks every output beat. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module image_pyramid_box_downsampler_test;
  import ipbd_pkg::*;

  localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int MAX_LV        = DEF_MAX_LEVELS;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PIXELS = 80;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_LEVELS = {REG_LEVEL_COUNT, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_SPARE  = {REG_SPARE, 2'b00};

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  level;
    logic [COLUMN_BITS-1:0] column;
    logic [ROW_BITS-1:0]    row;
    logic [SAMPLE_W-1:0]    value;
    logic                   last_of_run;
  } pyr_px_t;

  typedef enum {STEP_READ, STEP_WRITE, STEP_PIXEL} step_kind_t;
  typedef enum {FILL_RANDOM, FILL_FULL, FILL_EXTREMES, FILL_MIXED} fill_kind_t;

  typedef struct {
    step_kind_t               kind;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [31:0]              data;
    bit                       typed;
    pyr_px_t                  want;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SAMPLE_W-1:0]      sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [LEVEL_BITS-1:0]    level;
  logic [COLUMN_BITS-1:0]   column;
  logic [ROW_BITS-1:0]      row;
  logic [SAMPLE_W-1:0]      value;
  logic                     last_of_run;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  image_pyramid_box_downsampler dut (
    .clk, .rst,
    .in_valid, .in_ready, .sample,
    .out_valid, .out_ready, .level, .column, .row, .value, .last_of_run,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  logic [CFG_DIM_BITS-1:0]   cfg_width  = RESET_IMAGE_WIDTH;
  logic [CFG_DIM_BITS-1:0]   cfg_height = RESET_IMAGE_HEIGHT;
  logic [CFG_LEVEL_BITS-1:0] cfg_levels = RESET_LEVEL_COUNT;

  logic [9:0]          col_cnt   [0:MAX_LV];
  logic [9:0]          row_cnt   [0:MAX_LV];
  logic [SAMPLE_W-1:0] left_px   [0:MAX_LV-1];
  logic [SAMPLE_W:0]   pair_line [0:MAX_W-1];
  pyr_px_t             run_px    [0:MAX_LV-1];

  pyr_px_t expected_px[$];

  bit idling_on = 1'b1;
  int stall_left = 0;
  int mismatch_count = 0;
  int pixels_sent = 0;
  int frames_sent = 0;
  int pixels_checked = 0;
  int top_level_seen = 0;
  int cycle_count = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Walks one pixel up the pyramid; fills run_px and returns how many
  // output pixels it completes.
  function automatic int downsample_pixel(logic [SAMPLE_W-1:0] px);
    int unsigned w0, h0, nlev, w, h, x, y, c, r, base, idx, k;
    logic [SAMPLE_W-1:0] carry;
    logic [SAMPLE_W:0]   pair;
    logic [SAMPLE_W+1:0] blk;
    bit                  made;
    int                  count;
    w0 = clamp_to(cfg_width, 2, MAX_W);
    h0 = clamp_to(cfg_height, 2, MAX_H);
    nlev = clamp_to(cfg_levels, 1, MAX_LV);
    carry = px;
    count = 0;
    for (k = 0; k < nlev; k++) begin
      w = w0 >> k;
      h = h0 >> k;
      x = col_cnt[k];
      y = row_cnt[k];
      base = MAX_W - (MAX_W >> k);
      made = 1'b0;
      blk = '0;
      if (x < w && y < h) begin
        if (x % 2 == 0) begin
          if (x + 1 < w) left_px[k] = carry;
        end else begin
          pair = left_px[k] + carry;
          idx = base + (x >> 1);
          if (idx < MAX_W) begin
            if (y % 2 == 0) begin
              if (y + 1 < h) pair_line[idx] = pair;
            end else begin
              blk = pair_line[idx] + pair;
              made = 1'b1;
            end
          end
        end
      end
      c = x + 1;
      if (c >= w) begin
        c = 0;
        r = y + 1;
        if (r >= h) r = 0;
        row_cnt[k] = r;
      end
      col_cnt[k] = c;
      if (!made) break;
      run_px[count].level = LEVEL_BITS'(k + 1);
      run_px[count].column = COLUMN_BITS'(x >> 1);
      run_px[count].row = ROW_BITS'(y >> 1);
      run_px[count].value = blk[SAMPLE_W+1:2];
      run_px[count].last_of_run = 1'b0;
      count++;
      carry = blk[SAMPLE_W+1:2];
    end
    if (count > 0) run_px[count-1].last_of_run = 1'b1;
    return count;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(fill_kind_t fill);
    logic [SAMPLE_W-1:0] extreme;
    extreme = $urandom_range(0, 1) ? '1 : '0;
    case (fill)
      FILL_FULL: begin
        return '1;
      end
      FILL_EXTREMES: begin
        return extreme;
      end
      FILL_MIXED: begin
        return ($urandom_range(0, 3) == 0) ? extreme : SAMPLE_W'($urandom());
      end
      default: begin
        return SAMPLE_W'($urandom());
      end
    endcase
  endfunction

  function automatic logic [CFG_DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: begin
        return CFG_DIM_BITS'($urandom_range(0, 1));
      end
      1: begin
        return CFG_DIM_BITS'($urandom_range(15, 17));
      end
      default: begin
        return CFG_DIM_BITS'($urandom_range(2, 12));
      end
    endcase
  endfunction

  function automatic plan_row_t plan_step(step_kind_t kind, logic [CFG_ADDR_BITS-1:0] addr,
                                          logic [31:0] data, bit typed = 1'b0,
                                          pyr_px_t want = '0);
    plan_row_t s;
    s.kind = kind;
    s.addr = addr;
    s.data = data;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic pyr_px_t first_block(logic [SAMPLE_W-1:0] mean);
    pyr_px_t p;
    p.level = LEVEL_BITS'(1);
    p.column = '0;
    p.row = '0;
    p.value = mean;
    p.last_of_run = 1'b1;
    return p;
  endfunction

  task automatic apb_access(input bit wr, input logic [CFG_ADDR_BITS-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    if (wr) begin
      case (addr[CFG_ADDR_BITS-1:2])
        REG_IMAGE_WIDTH: begin
          cfg_width = wdata[CFG_DIM_BITS-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          cfg_height = wdata[CFG_DIM_BITS-1:0];
        end
        REG_LEVEL_COUNT: begin
          cfg_levels = wdata[CFG_LEVEL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Holds off the sender until every outstanding output beat is back and
  // the pipeline has had time to drain blocks that emit nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [SAMPLE_W-1:0] px, input bit typed,
                            input pyr_px_t want);
    int n, gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= px;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    n = downsample_pixel(px);
    if (typed) begin
      expected_px = {expected_px, want};
    end else begin
      for (int i = 0; i < n; i++) expected_px = {expected_px, run_px[i]};
    end
    pixels_sent++;
  endtask

  task automatic send_frame(input fill_kind_t fill);
    int unsigned w, h;
    w = clamp_to(cfg_width, 2, MAX_W);
    h = clamp_to(cfg_height, 2, MAX_H);
    for (int unsigned i = 0; i < w * h; i++) send_pixel(pick_sample(fill), 1'b0, '0);
    frames_sent++;
  endtask

  task automatic configure(input logic [CFG_DIM_BITS-1:0] w, input logic [CFG_DIM_BITS-1:0] h,
                           input logic [CFG_LEVEL_BITS-1:0] l);
    logic [31:0] junk, rd;
    settle();
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_F800) : '0;
    apb_access(1'b1, ADDR_WIDTH, junk | 32'(w), rd);
    apb_access(1'b1, ADDR_HEIGHT, junk | 32'(h), rd);
    apb_access(1'b1, ADDR_LEVELS, (junk & 32'hFFFF_FFF8) | 32'(l), rd);
    if ($urandom_range(0, 3) == 0) apb_access(1'b1, ADDR_SPARE, $urandom(), rd);
  endtask

  always @(posedge clk) begin : out_side
    pyr_px_t want_px;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_px.size() == 0) begin
        mismatch_count++;
        $error("unexpected beat: level %0d column %0d row %0d value %0d",
               level, column, row, value);
      end else begin
        want_px = expected_px.pop_front();
        compare_field("level", 32'(want_px.level), 32'(level));
        compare_field("column", 32'(want_px.column), 32'(column));
        compare_field("row", 32'(want_px.row), 32'(row));
        compare_field("value", 32'(want_px.value), 32'(value));
        compare_field("last_of_run", 32'(want_px.last_of_run), 32'(last_of_run));
        pixels_checked++;
        if (int'(want_px.level) > top_level_seen) top_level_seen = int'(want_px.level);
      end
    end
    if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    logic [31:0] rd;
    int random_pixels, start;
    for (int k = 0; k <= MAX_LV; k++) begin
      col_cnt[k] = '0;
      row_cnt[k] = '0;
    end
    for (int k = 0; k < MAX_LV; k++) left_px[k] = '0;
    for (int i = 0; i < MAX_W; i++) pair_line[i] = '0;

    plan = {plan, plan_step(STEP_READ, ADDR_WIDTH, 32'(RESET_IMAGE_WIDTH))};
    plan = {plan, plan_step(STEP_READ, ADDR_HEIGHT, 32'(RESET_IMAGE_HEIGHT))};
    plan = {plan, plan_step(STEP_READ, ADDR_LEVELS, 32'(RESET_LEVEL_COUNT))};
    plan = {plan, plan_step(STEP_WRITE, ADDR_WIDTH, 32'd2)};
    plan = {plan, plan_step(STEP_WRITE, ADDR_HEIGHT, 32'd2)};
    plan = {plan, plan_step(STEP_WRITE, ADDR_LEVELS, 32'd1)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF, 1'b1, first_block(16'hFFFF))};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'h0)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'h0)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'h0)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'h0, 1'b1, first_block(16'h0))};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFF)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'hFFFE, 1'b1, first_block(16'hFFFE))};
    plan = {plan, plan_step(STEP_WRITE, ADDR_WIDTH, 32'hFFFF_F801)};
    plan = {plan, plan_step(STEP_WRITE, ADDR_HEIGHT, 32'h0000_0802)};
    plan = {plan, plan_step(STEP_WRITE, ADDR_LEVELS, 32'd0)};
    plan = {plan, plan_step(STEP_WRITE, ADDR_SPARE, 32'hFFFF_FFFF)};
    plan = {plan, plan_step(STEP_READ, ADDR_WIDTH, 32'd1)};
    plan = {plan, plan_step(STEP_READ, ADDR_HEIGHT, 32'd2)};
    plan = {plan, plan_step(STEP_READ, ADDR_LEVELS, 32'd0)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'd1)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'd2)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'd3)};
    plan = {plan, plan_step(STEP_PIXEL, '0, 32'd4, 1'b1, first_block(16'd2))};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_READ: begin
          apb_access(1'b0, plan[i].addr, '0, rd);
          compare_field("prdata", plan[i].data, rd);
        end
        STEP_WRITE: begin
          settle();
          apb_access(1'b1, plan[i].addr, plan[i].data, rd);
        end
        default: begin
          send_pixel(plan[i].data[SAMPLE_W-1:0], plan[i].typed, plan[i].want);
        end
      endcase
    end

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      configure(pick_dim(), pick_dim(), CFG_LEVEL_BITS'($urandom_range(0, 7)));
      idling_on = ($urandom_range(0, 3) != 0);
      start = pixels_sent;
      send_frame(fill_kind_t'($urandom_range(0, 3)));
      random_pixels += pixels_sent - start;
    end

    idling_on = 1'b1;
    configure(11'd9, 11'd5, 3'd5);
    send_frame(FILL_MIXED);
    configure(11'd8, 11'd8, 3'd7);
    idling_on = 1'b0;
    send_frame(FILL_MIXED);

    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Streamed %0d pixels in %0d frames; %0d pyramid pixels checked up to level %0d.",
             pixels_sent, frames_sent, pixels_checked, top_level_seen);
    $display("Frames went from 2x2 up to 17x17 with out-of-range sizes and level counts.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
